FILE: hw/rtl/srci_pkg.sv
`default_nettype none
package srci_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int CHANNELS    = 2;
    localparam int HISTORY_LEN = 4;
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DITHER_BITS = 16;
    localparam int FILL_W      = $clog2(HISTORY_LEN + 1);

    // Shared multiplier operand and product widths.
    localparam int MA_W = 46;
    localparam int MB_W = 25;
    localparam int MP_W = MA_W + MB_W;

    localparam int DIVIDEND_W = 34;
    localparam int STEP_W     = 23;
    localparam int RATIO_W    = 17;
    localparam int GAIN_W     = 16;
    localparam int POS_W      = 17;
    localparam int PHASE_W    = 18;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [MP_W-1:0]        prod_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE_RATIO    = 3'd0,
        CFG_LOWPASS_ALPHA = 3'd1,
        CFG_QUANT_STEP    = 3'd2,
        CFG_DITHER_GAIN   = 3'd3,
        CFG_SHAPING_GAIN  = 3'd4
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_PHASE, ST_DTH1, ST_DTH2, ST_X,
        ST_LP1A, ST_LP1B, ST_LP1C, ST_LP2A, ST_LP2B, ST_LP2C,
        ST_SHP1, ST_SHP2, ST_DIV, ST_HELD, ST_POS,
        ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6,
        ST_NEXT, ST_DONE
    } state_t;

    typedef struct packed {
        logic                         start;
        logic signed [DIVIDEND_W-1:0] dividend;
        logic [STEP_W-1:0]            divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [STEP_W-1:0] rem;
    } div_rsp_t;

    function automatic sample_t sat_sample(input prod_t v);
        prod_t hi;
        prod_t lo;
        hi = prod_t'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
        lo = -hi - prod_t'(1);
        if (v > hi)
            return sample_t'(hi);
        else if (v < lo)
            return sample_t'(lo);
        else
            return sample_t'(v);
    endfunction

    function automatic logic signed [31:0] sat_word32(input prod_t v);
        prod_t hi;
        prod_t lo;
        hi = prod_t'(64'sd2147483647);
        lo = -hi - prod_t'(1);
        if (v > hi)
            return 32'(hi);
        else if (v < lo)
            return 32'(lo);
        else
            return 32'(v);
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/sample_rate_crusher_interpolator.sv
`default_nettype none
// Channel   Signals                                          Direction
// input     in_valid, in_stall, sample_left/right,           word in
//           dither_left/right
// output    out_valid, out_stall, out_left/right             word out
// config    cfg_we, cfg_index, cfg_data                      register write
//
// The channels are worked one after the other through one shared multiplier; each channel
// that captures a new held value waits on the serial remainder unit that floors to the
// step, and each full channel also works through the cubic.
// The block accepts a new word only when its sequencer is idle, and a finished
// result waits in the output register while the next word is worked on.
// Reset is asynchronous and active low; it clears the channel phase, position, filter, error
// and fill state and the configuration registers to their defaults. A stall on the output only
// holds the sequencer at its final step when the previous result has not been taken.
module sample_rate_crusher_interpolator (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [srci_pkg::SAMPLE_BITS-1:0] sample_left,
    input  wire logic signed [srci_pkg::SAMPLE_BITS-1:0] sample_right,
    input  wire logic signed [srci_pkg::DITHER_BITS-1:0] dither_left,
    input  wire logic signed [srci_pkg::DITHER_BITS-1:0] dither_right,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [srci_pkg::SAMPLE_BITS-1:0]  out_left,
    output logic signed [srci_pkg::SAMPLE_BITS-1:0]  out_right,
    input  wire logic                                cfg_we,
    input  wire logic [srci_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [srci_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CH  = srci_pkg::CHANNELS;
    localparam int HL  = srci_pkg::HISTORY_LEN;
    localparam int MAW = srci_pkg::MA_W;
    localparam int MBW = srci_pkg::MB_W;

    // Configuration registers.
    logic [srci_pkg::RATIO_W-1:0] rate_ratio_reg;
    logic [16:0]                  lowpass_alpha_reg;
    logic [srci_pkg::STEP_W-1:0]  quant_step_reg;
    logic [srci_pkg::GAIN_W-1:0]  dither_gain_reg;
    logic [16:0]                  shaping_gain_reg;

    // Per-channel state.
    logic signed [srci_pkg::PHASE_W-1:0] phase_reg [CH];
    logic [srci_pkg::POS_W-1:0]          pos_reg   [CH];
    logic signed [31:0]                  lp1_reg   [CH];
    logic signed [31:0]                  lp2_reg   [CH];
    srci_pkg::sample_t                   err_reg   [CH];
    logic [srci_pkg::FILL_W-1:0]         fill_reg  [CH];
    srci_pkg::sample_t                   hist_reg  [CH][HL];
    srci_pkg::sample_t                   res_reg   [CH];
    srci_pkg::sample_t                   samp_reg  [CH];
    logic signed [srci_pkg::DITHER_BITS-1:0] dth_reg [CH];

    // Sequencer and working registers.
    srci_pkg::state_t                    state_reg;
    srci_pkg::state_t                    state_next;
    logic [srci_pkg::CH_W-1:0]           ch_reg;
    logic                                all_full_reg;
    logic signed [29:0]                  x_reg;
    srci_pkg::prod_t                     acc_reg;
    logic signed [srci_pkg::DIVIDEND_W-1:0] shaped_reg;
    logic                                out_valid_reg;
    srci_pkg::sample_t                   out_left_reg;
    srci_pkg::sample_t                   out_right_reg;

    logic signed [MAW-1:0] mul_a;
    logic signed [MBW-1:0] mul_b;
    srci_pkg::prod_t       prod;
    srci_pkg::div_req_t    div_req;
    srci_pkg::div_rsp_t    div_rsp;

    logic [srci_pkg::STEP_W-1:0]         step_eff;
    logic [16:0]                         alpha_eff;
    logic [16:0]                         beta_eff;
    logic signed [srci_pkg::PHASE_W:0]   phase_sum;
    logic                                capture;
    logic [srci_pkg::POS_W:0]            pos_sum;
    logic [srci_pkg::POS_W-1:0]          pos_next;
    logic                                last_ch;
    logic                                is_full;
    logic                                out_free;
    srci_pkg::prod_t                     p0, p1, p2, p3;
    srci_pkg::prod_t                     cf_a, cf_b, cf_c, cf_d;
    logic signed [srci_pkg::DIVIDEND_W-1:0] shaped_w;
    srci_pkg::sample_t                   held_w;
    srci_pkg::sample_t                   err_w;
    logic signed [31:0]                  lp_new;

    srci_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    srci_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // A step of zero behaves as one, and alpha saturates at unity.
    assign step_eff  = (quant_step_reg == '0) ? srci_pkg::STEP_W'(1) : quant_step_reg;
    assign alpha_eff = (lowpass_alpha_reg > 17'd65536) ? 17'd65536 : lowpass_alpha_reg;
    assign beta_eff  = 17'd65536 - alpha_eff;

    assign phase_sum = (srci_pkg::PHASE_W + 1)'(phase_reg[ch_reg])
                     + $signed({2'b00, rate_ratio_reg});
    assign capture   = (phase_sum >= $signed((srci_pkg::PHASE_W + 1)'(65536)));

    // The interpolation position grows with the ratio and stops at unity.
    assign pos_sum  = (srci_pkg::POS_W + 1)'(pos_reg[ch_reg])
                    + (srci_pkg::POS_W + 1)'(rate_ratio_reg);
    assign pos_next = (pos_sum > (srci_pkg::POS_W + 1)'(65536))
                    ? srci_pkg::POS_W'(65536) : srci_pkg::POS_W'(pos_sum);

    assign last_ch  = (ch_reg == srci_pkg::CH_W'(CH - 1));
    assign is_full  = (fill_reg[ch_reg] == srci_pkg::FILL_W'(HL));
    assign out_free = !out_valid_reg || !out_stall;

    // Catmull-Rom coefficients of the current channel's history.
    assign p0   = srci_pkg::prod_t'(hist_reg[ch_reg][0]);
    assign p1   = srci_pkg::prod_t'(hist_reg[ch_reg][1]);
    assign p2   = srci_pkg::prod_t'(hist_reg[ch_reg][2]);
    assign p3   = srci_pkg::prod_t'(hist_reg[ch_reg][3]);
    assign cf_a = p1 + p1;
    assign cf_b = p2 - p0;
    assign cf_c = p0 + p0 - p1 * 5 + p2 * 4 - p3;
    assign cf_d = p1 * 3 - p0 - p2 * 3 + p3;

    assign lp_new   = srci_pkg::sat_word32((acc_reg + prod) >>> 16);
    assign shaped_w = srci_pkg::DIVIDEND_W'(srci_pkg::prod_t'(lp2_reg[ch_reg]) - (prod >>> 16));
    assign held_w   = srci_pkg::sat_sample(srci_pkg::prod_t'(shaped_reg)
                                         - srci_pkg::prod_t'(div_rsp.rem));
    assign err_w    = srci_pkg::sat_sample(srci_pkg::prod_t'(held_w)
                                         - srci_pkg::prod_t'(shaped_reg));

    assign div_req.start    = (state_reg == srci_pkg::ST_SHP2);
    assign div_req.dividend = shaped_w;
    assign div_req.divisor  = step_eff;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            srci_pkg::ST_IDLE:  if (in_valid) state_next = srci_pkg::ST_PHASE;
            srci_pkg::ST_PHASE: state_next = capture ? srci_pkg::ST_DTH1 : srci_pkg::ST_POS;
            srci_pkg::ST_DTH1:  state_next = srci_pkg::ST_DTH2;
            srci_pkg::ST_DTH2:  state_next = srci_pkg::ST_X;
            srci_pkg::ST_X:     state_next = srci_pkg::ST_LP1A;
            srci_pkg::ST_LP1A:  state_next = srci_pkg::ST_LP1B;
            srci_pkg::ST_LP1B:  state_next = srci_pkg::ST_LP1C;
            srci_pkg::ST_LP1C:  state_next = srci_pkg::ST_LP2A;
            srci_pkg::ST_LP2A:  state_next = srci_pkg::ST_LP2B;
            srci_pkg::ST_LP2B:  state_next = srci_pkg::ST_LP2C;
            srci_pkg::ST_LP2C:  state_next = srci_pkg::ST_SHP1;
            srci_pkg::ST_SHP1:  state_next = srci_pkg::ST_SHP2;
            srci_pkg::ST_SHP2:  state_next = srci_pkg::ST_DIV;
            srci_pkg::ST_DIV:   if (div_rsp.done) state_next = srci_pkg::ST_HELD;
            srci_pkg::ST_HELD:  state_next = srci_pkg::ST_POS;
            srci_pkg::ST_POS:   state_next = is_full ? srci_pkg::ST_C1 : srci_pkg::ST_NEXT;
            srci_pkg::ST_C1:    state_next = srci_pkg::ST_C2;
            srci_pkg::ST_C2:    state_next = srci_pkg::ST_C3;
            srci_pkg::ST_C3:    state_next = srci_pkg::ST_C4;
            srci_pkg::ST_C4:    state_next = srci_pkg::ST_C5;
            srci_pkg::ST_C5:    state_next = srci_pkg::ST_C6;
            srci_pkg::ST_C6:    state_next = srci_pkg::ST_NEXT;
            srci_pkg::ST_NEXT:  state_next = last_ch ? srci_pkg::ST_DONE : srci_pkg::ST_PHASE;
            srci_pkg::ST_DONE:  if (!all_full_reg || out_free) state_next = srci_pkg::ST_IDLE;
            default:            state_next = srci_pkg::ST_IDLE;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            srci_pkg::ST_DTH1:
            begin
                mul_a = MAW'(dth_reg[ch_reg]);
                mul_b = $signed(MBW'(step_eff));
            end
            srci_pkg::ST_DTH2:
            begin
                mul_a = $signed(prod[MAW-1:0]);
                mul_b = $signed(MBW'(dither_gain_reg));
            end
            srci_pkg::ST_LP1A:
            begin
                mul_a = MAW'(x_reg);
                mul_b = $signed(MBW'(alpha_eff));
            end
            srci_pkg::ST_LP1B:
            begin
                mul_a = MAW'(lp1_reg[ch_reg]);
                mul_b = $signed(MBW'(beta_eff));
            end
            srci_pkg::ST_LP2A:
            begin
                mul_a = MAW'(lp1_reg[ch_reg]);
                mul_b = $signed(MBW'(alpha_eff));
            end
            srci_pkg::ST_LP2B:
            begin
                mul_a = MAW'(lp2_reg[ch_reg]);
                mul_b = $signed(MBW'(beta_eff));
            end
            srci_pkg::ST_SHP1:
            begin
                mul_a = MAW'(err_reg[ch_reg]);
                mul_b = $signed(MBW'(shaping_gain_reg));
            end
            srci_pkg::ST_C1:
            begin
                mul_a = MAW'(cf_d);
                mul_b = $signed(MBW'(pos_reg[ch_reg]));
            end
            srci_pkg::ST_C3, srci_pkg::ST_C5:
            begin
                mul_a = $signed(acc_reg[MAW-1:0]);
                mul_b = $signed(MBW'(pos_reg[ch_reg]));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srci_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration writes; codes outside the register list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_ratio_reg    <= srci_pkg::RATIO_W'(32768);
            lowpass_alpha_reg <= 17'd65536;
            quant_step_reg    <= srci_pkg::STEP_W'(512);
            dither_gain_reg   <= '0;
            shaping_gain_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                srci_pkg::CFG_RATE_RATIO:    rate_ratio_reg    <= cfg_data[16:0];
                srci_pkg::CFG_LOWPASS_ALPHA: lowpass_alpha_reg <= cfg_data[16:0];
                srci_pkg::CFG_QUANT_STEP:    quant_step_reg    <= cfg_data;
                srci_pkg::CFG_DITHER_GAIN:   dither_gain_reg   <= cfg_data[15:0];
                srci_pkg::CFG_SHAPING_GAIN:  shaping_gain_reg  <= cfg_data[16:0];
                default:                     ;
            endcase
        end
    end

    // Channel state, sequencer bookkeeping and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CH; c++)
            begin
                phase_reg[c] <= '0;
                pos_reg[c]   <= '0;
                lp1_reg[c]   <= '0;
                lp2_reg[c]   <= '0;
                err_reg[c]   <= '0;
                fill_reg[c]  <= '0;
            end
            ch_reg        <= '0;
            all_full_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A new result replaces the old one in the same cycle it is taken.
            if (state_reg == srci_pkg::ST_DONE && all_full_reg && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                srci_pkg::ST_IDLE:
                begin
                    ch_reg       <= '0;
                    all_full_reg <= 1'b1;
                end
                srci_pkg::ST_PHASE:
                begin
                    phase_reg[ch_reg] <= capture
                                       ? -$signed(srci_pkg::PHASE_W'(65536))
                                       : srci_pkg::PHASE_W'(phase_sum);
                end
                srci_pkg::ST_LP1C: lp1_reg[ch_reg] <= lp_new;
                srci_pkg::ST_LP2C: lp2_reg[ch_reg] <= lp_new;
                srci_pkg::ST_HELD:
                begin
                    pos_reg[ch_reg] <= '0;
                    if (fill_reg[ch_reg] < srci_pkg::FILL_W'(HL))
                        fill_reg[ch_reg] <= fill_reg[ch_reg] + srci_pkg::FILL_W'(1);
                    if (shaping_gain_reg != '0)
                        err_reg[ch_reg] <= err_w;
                end
                srci_pkg::ST_POS:
                begin
                    if (!is_full)
                        all_full_reg <= 1'b0;
                end
                srci_pkg::ST_NEXT:
                begin
                    pos_reg[ch_reg] <= pos_next;
                    ch_reg          <= ch_reg + srci_pkg::CH_W'(1);
                end
                default: ;
            endcase
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            srci_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    samp_reg[0] <= sample_left;
                    samp_reg[1] <= sample_right;
                    dth_reg[0]  <= dither_left;
                    dth_reg[1]  <= dither_right;
                end
            end
            srci_pkg::ST_X:
                x_reg <= 30'(srci_pkg::prod_t'(samp_reg[ch_reg]) + (prod >>> 27));
            srci_pkg::ST_LP1B, srci_pkg::ST_LP2B:
                acc_reg <= prod;
            srci_pkg::ST_SHP2:
                shaped_reg <= shaped_w;
            srci_pkg::ST_HELD:
            begin
                // The history always shifts; entries not yet filled are never read.
                for (int k = 0; k < HL - 1; k++)
                    hist_reg[ch_reg][k] <= hist_reg[ch_reg][k + 1];
                hist_reg[ch_reg][HL - 1] <= held_w;
            end
            srci_pkg::ST_C2:
                acc_reg <= prod + (cf_c <<< 16);
            srci_pkg::ST_C4:
                acc_reg <= (prod + (cf_b <<< 32)) >>> 16;
            srci_pkg::ST_C6:
                res_reg[ch_reg] <= srci_pkg::sat_sample(
                    (prod + (cf_a <<< 32) + (srci_pkg::prod_t'(1) <<< 32)) >>> 33);
            srci_pkg::ST_DONE:
            begin
                if (all_full_reg && out_free)
                begin
                    out_left_reg  <= res_reg[0];
                    out_right_reg <= res_reg[1];
                end
            end
            default: ;
        endcase
    end

    assign in_stall  = (state_reg != srci_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_left  = out_left_reg;
    assign out_right = out_right_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/srci_mul.sv
`default_nettype none
module srci_mul (
    input  wire logic                          clk,
    input  wire logic signed [srci_pkg::MA_W-1:0] a,
    input  wire logic signed [srci_pkg::MB_W-1:0] b,
    output srci_pkg::prod_t                    p
);

    srci_pkg::prod_t p_reg;

    // One signed product per cycle, registered.
    always_ff @(posedge clk)
    begin
        p_reg <= srci_pkg::prod_t'(a) * srci_pkg::prod_t'(b);
    end

    assign p = p_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/srci_div.sv
`default_nettype none
module srci_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  srci_pkg::div_req_t      req,
    output srci_pkg::div_rsp_t      rsp
);

    localparam int CNT_W = $clog2(srci_pkg::DIVIDEND_W + 1);

    logic [srci_pkg::DIVIDEND_W-1:0] mag_reg;
    logic [srci_pkg::STEP_W:0]       rem_reg;
    logic [srci_pkg::STEP_W-1:0]     dvs_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;
    logic                            neg_reg;

    logic [srci_pkg::DIVIDEND_W:0]   neg_w;
    logic [srci_pkg::STEP_W:0]       trial_w;
    logic [srci_pkg::STEP_W-1:0]     rem_mag_w;

    assign neg_w   = (srci_pkg::DIVIDEND_W + 1)'(0)
                   - {req.dividend[srci_pkg::DIVIDEND_W-1], req.dividend};
    assign trial_w = {rem_reg[srci_pkg::STEP_W-1:0], mag_reg[srci_pkg::DIVIDEND_W-1]};

    // Restoring division of the magnitude, one quotient bit per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(srci_pkg::DIVIDEND_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg <= req.dividend[srci_pkg::DIVIDEND_W-1];
            mag_reg <= req.dividend[srci_pkg::DIVIDEND_W-1]
                     ? neg_w[srci_pkg::DIVIDEND_W-1:0]
                     : req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            mag_reg <= {mag_reg[srci_pkg::DIVIDEND_W-2:0], 1'b0};
            if (trial_w >= {1'b0, dvs_reg})
                rem_reg <= trial_w - {1'b0, dvs_reg};
            else
                rem_reg <= trial_w;
        end
    end

    // Floor remainder: a nonzero remainder of a negative dividend wraps to step - r.
    assign rem_mag_w = rem_reg[srci_pkg::STEP_W-1:0];
    assign rsp.done  = done_reg;
    assign rsp.rem   = (neg_reg && (rem_mag_w != '0)) ? (dvs_reg - rem_mag_w) : rem_mag_w;

endmodule
`default_nettype wire

FILE: hw/rtl/srci_chk.sv
`default_nettype none
module srci_chk (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_stall,
    input wire logic                                out_valid,
    input wire logic                                out_stall,
    input wire logic signed [srci_pkg::SAMPLE_BITS-1:0] out_left,
    input wire logic signed [srci_pkg::SAMPLE_BITS-1:0] out_right
);

    // A word that was just taken keeps the input closed while it is worked on.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input open right after a word was accepted");

    // A new result only appears at the end of a word's work.
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without work in progress");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_left) && $stable(out_right)))
        else $error("stalled result changed");

endmodule

bind sample_rate_crusher_interpolator srci_chk u_srci_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_left  (out_left),
    .out_right (out_right)
);
`default_nettype wire

FILE: test/tb_sample_rate_crusher_interpolator.sv
`timescale 1ns / 1ps

module tb_sample_rate_crusher_interpolator;

    // Cycles in which no word is accepted or taken before the run is declared hung. The
    // settling pause between phases and the pause that waits for the block to
    // drain both count toward it, so it is set well above them.
    localparam int IDLE_LIMIT  = 6000;
    // Settle well past the work of the slowest word before touching the
    // registers or ending the run.
    localparam int SETTLE_CYC  = 250;
    localparam longint ONE_Q16 = 65536;

    typedef struct {
        logic signed [srci_pkg::SAMPLE_BITS-1:0] smp [srci_pkg::CHANNELS];
        logic signed [srci_pkg::DITHER_BITS-1:0] dth [srci_pkg::CHANNELS];
    } frame_t;

    typedef struct {
        logic signed [srci_pkg::SAMPLE_BITS-1:0] smp [srci_pkg::CHANNELS];
    } crushed_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [srci_pkg::SAMPLE_BITS-1:0] sample_left;
    logic signed [srci_pkg::SAMPLE_BITS-1:0] sample_right;
    logic signed [srci_pkg::DITHER_BITS-1:0] dither_left;
    logic signed [srci_pkg::DITHER_BITS-1:0] dither_right;
    logic out_valid;
    logic out_stall;
    logic signed [srci_pkg::SAMPLE_BITS-1:0] out_left;
    logic signed [srci_pkg::SAMPLE_BITS-1:0] out_right;
    logic cfg_we;
    logic [srci_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [srci_pkg::CFG_DATA_W-1:0] cfg_data;

    sample_rate_crusher_interpolator u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample_left (sample_left),
        .sample_right(sample_right),
        .dither_left (dither_left),
        .dither_right(dither_right),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_left    (out_left),
        .out_right   (out_right),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Frames waiting to be driven, and output pairs the predictor expects.
    frame_t   frame_q[$];
    crushed_t crushed_q[$];

    // Shadow copy of the block's registers and per-channel state.
    longint rate_ratio_r, alpha_r, step_r, dgain_r, sgain_r;
    longint phase_s [srci_pkg::CHANNELS];
    longint pos_s   [srci_pkg::CHANNELS];
    longint lp1_s   [srci_pkg::CHANNELS];
    longint lp2_s   [srci_pkg::CHANNELS];
    longint shperr_s[srci_pkg::CHANNELS];
    longint hist_s  [srci_pkg::CHANNELS][srci_pkg::HISTORY_LEN];
    int     fill_s  [srci_pkg::CHANNELS];

    int  fail_cnt;
    int  frames_sent;
    int  pairs_checked;
    int  idle_cycles;
    bit  quiet;        // no idling on either side in the closing phase
    bit  took;         // set at the edge where the input word was accepted
    int  in_gap;
    int  out_gap;

    function automatic longint sat_bits(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function automatic longint floor_div(input longint v, input longint d);
        longint q;
        q = v / d;
        if ((v % d) != 0 && v < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint one_pole(input longint x, input longint prev, input longint a);
        return sat_bits((a * x + (ONE_Q16 - a) * prev) >>> 16, 32);
    endfunction

    // Cubic spline through the history by Horner in Q16, rounded and saturated.
    function automatic longint spline_at(input int ch, input longint t);
        longint p0, p1, p2, p3, ca, cb, cc, cd, acc;
        p0 = hist_s[ch][0];
        p1 = hist_s[ch][1];
        p2 = hist_s[ch][2];
        p3 = hist_s[ch][3];
        ca = 2 * p1;
        cb = p2 - p0;
        cc = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        cd = -p0 + 3 * p1 - 3 * p2 + p3;
        acc = cd * t + cc * ONE_Q16;
        acc = (acc * t + cb * (longint'(1) <<< 32)) >>> 16;
        acc = acc * t + ca * (longint'(1) <<< 32);
        return sat_bits((acc + (longint'(1) <<< 32)) >>> 33, srci_pkg::SAMPLE_BITS);
    endfunction

    // Filters, shapes and quantizes one new held value for a channel.
    task automatic capture_held(input int ch, input longint x, input longint d);
        longint step, a, shaped, held;
        step = (step_r != 0) ? step_r : 1;
        a = (alpha_r > ONE_Q16) ? ONE_Q16 : alpha_r;
        x = x + ((d * step * dgain_r) >>> 27);
        lp1_s[ch] = one_pole(x, lp1_s[ch], a);
        lp2_s[ch] = one_pole(lp1_s[ch], lp2_s[ch], a);
        shaped = lp2_s[ch] - ((sgain_r * shperr_s[ch]) >>> 16);
        held = sat_bits(floor_div(shaped, step) * step, srci_pkg::SAMPLE_BITS);
        if (fill_s[ch] < srci_pkg::HISTORY_LEN)
        begin
            hist_s[ch][fill_s[ch]] = held;
            fill_s[ch]++;
        end
        else
        begin
            for (int k = 0; k < srci_pkg::HISTORY_LEN - 1; k++)
                hist_s[ch][k] = hist_s[ch][k + 1];
            hist_s[ch][srci_pkg::HISTORY_LEN - 1] = held;
        end
        pos_s[ch] = 0;
        if (sgain_r != 0)
            shperr_s[ch] = sat_bits(held - shaped, 24);
    endtask

    // Advances the shadow state by one frame and queues the output pair, if any.
    task automatic predict_crush(input frame_t f);
        crushed_t r;
        bit full;
        longint t;
        full = 1'b1;
        for (int ch = 0; ch < srci_pkg::CHANNELS; ch++)
        begin
            phase_s[ch] = phase_s[ch] + rate_ratio_r;
            if (phase_s[ch] >= ONE_Q16)
            begin
                phase_s[ch] = -ONE_Q16;
                capture_held(ch, longint'(f.smp[ch]), longint'(f.dth[ch]));
            end
            if (fill_s[ch] == srci_pkg::HISTORY_LEN)
            begin
                t = (pos_s[ch] > ONE_Q16) ? ONE_Q16 : pos_s[ch];
                r.smp[ch] = srci_pkg::SAMPLE_BITS'(spline_at(ch, t));
            end
            else
            begin
                r.smp[ch] = '0;
                full = 1'b0;
            end
            t = pos_s[ch] + rate_ratio_r;
            pos_s[ch] = (t > ONE_Q16) ? ONE_Q16 : t;
        end
        if (full)
            crushed_q.insert(crushed_q.size(), r);
    endtask

    // Register write at the falling edge; the shadow copy follows at once
    // because writes only happen while the block is idle.
    task automatic write_reg(input srci_pkg::cfg_idx_t idx, input longint val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= srci_pkg::CFG_DATA_W'(val);
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            srci_pkg::CFG_RATE_RATIO:    rate_ratio_r = val & 64'h1FFFF;
            srci_pkg::CFG_LOWPASS_ALPHA: alpha_r      = val & 64'h1FFFF;
            srci_pkg::CFG_QUANT_STEP:    step_r       = val & 64'h7FFFFF;
            srci_pkg::CFG_DITHER_GAIN:   dgain_r      = val & 64'hFFFF;
            srci_pkg::CFG_SHAPING_GAIN:  sgain_r      = val & 64'h1FFFF;
            default: ;
        endcase
    endtask

    // Holds the sender back until every expected pair has come out, then lets
    // a word with no result finish inside the block as well.
    task automatic drain_block();
        while (frame_q.size() != 0 || in_valid || crushed_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic push_frame(input longint sl, input longint sr,
                              input longint dl, input longint dr);
        frame_t f;
        f.smp[0] = srci_pkg::SAMPLE_BITS'(sl);
        f.smp[1] = srci_pkg::SAMPLE_BITS'(sr);
        f.dth[0] = srci_pkg::DITHER_BITS'(dl);
        f.dth[1] = srci_pkg::DITHER_BITS'(dr);
        frame_q.insert(frame_q.size(), f);
    endtask

    // Mostly full-range random words, with the field extremes mixed in.
    task automatic push_random(input int n);
        longint sl, sr;
        for (int i = 0; i < n; i++)
        begin
            sl = $urandom();
            sr = $urandom();
            case ($urandom_range(0, 9))
                0: sl = 24'h7FFFFF;
                1: sl = 24'h800000;
                2: sr = 24'h7FFFFF;
                3: sr = 24'h800000;
                4: begin sl = $urandom_range(0, 4095); sr = -sl; end
                default: ;
            endcase
            push_frame(sl, sr, $urandom(), $urandom());
        end
    endtask

    task automatic random_settings();
        case ($urandom_range(0, 3))
            0: write_reg(srci_pkg::CFG_RATE_RATIO, 65536);
            default: write_reg(srci_pkg::CFG_RATE_RATIO, $urandom_range(16384, 65536));
        endcase
        case ($urandom_range(0, 5))
            0: write_reg(srci_pkg::CFG_LOWPASS_ALPHA, 0);
            1: write_reg(srci_pkg::CFG_LOWPASS_ALPHA, 131071);
            2: write_reg(srci_pkg::CFG_LOWPASS_ALPHA, 65536);
            default: write_reg(srci_pkg::CFG_LOWPASS_ALPHA, $urandom_range(1, 65535));
        endcase
        case ($urandom_range(0, 5))
            0: write_reg(srci_pkg::CFG_QUANT_STEP, 0);
            1: write_reg(srci_pkg::CFG_QUANT_STEP, 1);
            2: write_reg(srci_pkg::CFG_QUANT_STEP, 4194304);
            3: write_reg(srci_pkg::CFG_QUANT_STEP, $urandom_range(1, 4194304));
            default: write_reg(srci_pkg::CFG_QUANT_STEP, $urandom_range(1, 4096));
        endcase
        case ($urandom_range(0, 3))
            0: write_reg(srci_pkg::CFG_DITHER_GAIN, 0);
            1: write_reg(srci_pkg::CFG_DITHER_GAIN, 65535);
            default: write_reg(srci_pkg::CFG_DITHER_GAIN, $urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 3))
            0: write_reg(srci_pkg::CFG_SHAPING_GAIN, 0);
            1: write_reg(srci_pkg::CFG_SHAPING_GAIN, 65536);
            default: write_reg(srci_pkg::CFG_SHAPING_GAIN, $urandom_range(0, 65536));
        endcase
    endtask

    // Input driver: a new word goes out at the falling edge once the previous
    // one was taken; random bursts of idle cycles fall between words outside the closing phase.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || took))
        begin
            took = 1'b0;
            if (!quiet && in_gap == 0 && $urandom_range(0, 9) == 0)
                in_gap = $urandom_range(1, 17);
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (frame_q.size() != 0)
            begin
                frame_t f;
                f = frame_q[0];
                frame_q.delete(0);
                sample_left  <= f.smp[0];
                sample_right <= f.smp[1];
                dither_left  <= f.dth[0];
                dither_right <= f.dth[1];
                in_valid     <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Output stall in random bursts, none during the closing phase.
    always @(negedge clk)
    begin
        if (!quiet && out_gap == 0 && $urandom_range(0, 7) == 0)
            out_gap = $urandom_range(1, 17);
        if (out_gap > 0)
        begin
            out_gap--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Acceptance on both channels, the scoreboard check, and the watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            bit moved;
            moved = 1'b0;
            if (in_valid && !in_stall)
            begin
                frame_t f;
                f.smp[0] = sample_left;
                f.smp[1] = sample_right;
                f.dth[0] = dither_left;
                f.dth[1] = dither_right;
                predict_crush(f);
                took = 1'b1;
                frames_sent++;
                moved = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                if (crushed_q.size() == 0)
                begin
                    $error("output pair with nothing expected: out_left=%0d out_right=%0d",
                           out_left, out_right);
                    fail_cnt++;
                end
                else
                begin
                    crushed_t r;
                    r = crushed_q[0];
                    crushed_q.delete(0);
                    pairs_checked++;
                    if (out_left !== r.smp[0])
                    begin
                        $error("out_left expected %0d actual %0d", r.smp[0], out_left);
                        fail_cnt++;
                    end
                    if (out_right !== r.smp[1])
                    begin
                        $error("out_right expected %0d actual %0d", r.smp[1], out_right);
                        fail_cnt++;
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        in_valid     = 1'b0;
        out_stall    = 1'b0;
        sample_left  = '0;
        sample_right = '0;
        dither_left  = '0;
        dither_right = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        fail_cnt = 0;
        frames_sent = 0;
        pairs_checked = 0;
        idle_cycles = 0;
        quiet = 1'b0;
        took = 1'b0;
        in_gap = 0;
        out_gap = 0;
        rate_ratio_r = 32768;
        alpha_r = 65536;
        step_r = 512;
        dgain_r = 0;
        sgain_r = 0;
        for (int ch = 0; ch < srci_pkg::CHANNELS; ch++)
        begin
            phase_s[ch] = 0;
            pos_s[ch] = 0;
            lp1_s[ch] = 0;
            lp2_s[ch] = 0;
            shperr_s[ch] = 0;
            fill_s[ch] = 0;
            for (int k = 0; k < srci_pkg::HISTORY_LEN; k++)
                hist_s[ch][k] = 0;
        end

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset settings: field extremes while the
        // history is still filling (no result yet), then past the full point.
        push_frame(24'h7FFFFF, 24'h800000, 16'h7FFF, 16'h8000);
        push_frame(24'h800000, 24'h7FFFFF, 16'h8000, 16'h7FFF);
        push_frame(0, 0, 0, 0);
        push_frame(-1, 1, -1, 1);
        push_frame(24'h7FFFFF, 24'h7FFFFF, 16'h7FFF, 16'h7FFF);
        push_frame(24'h800000, 24'h800000, 16'h8000, 16'h8000);
        push_frame(24'h555555, 24'hAAAAAA, 16'h5555, 16'hAAAA);
        push_frame(24'hAAAAAA, 24'h555555, 16'hAAAA, 16'h5555);
        push_random(8);
        drain_block();

        // Strongest dither and shaping, a one-LSB step, and an alpha above the
        // 1.0 clamp, at a ratio of one so that every second word captures.
        write_reg(srci_pkg::CFG_RATE_RATIO, 65536);
        write_reg(srci_pkg::CFG_LOWPASS_ALPHA, 131071);
        write_reg(srci_pkg::CFG_QUANT_STEP, 1);
        write_reg(srci_pkg::CFG_DITHER_GAIN, 65535);
        write_reg(srci_pkg::CFG_SHAPING_GAIN, 65536);
        push_frame(24'h7FFFFF, 24'h800000, 16'h7FFF, 16'h8000);
        push_frame(24'h7FFFFF, 24'h800000, 16'h7FFF, 16'h8000);
        push_frame(24'h800000, 24'h7FFFFF, 16'h8000, 16'h7FFF);
        push_random(6);
        drain_block();

        // A zero step is treated as one; a zero ratio stops all captures and
        // freezes the output.
        write_reg(srci_pkg::CFG_QUANT_STEP, 0);
        write_reg(srci_pkg::CFG_RATE_RATIO, 0);
        push_random(6);
        drain_block();

        // Random phases with new settings each time; the closing phase runs
        // without idling on either side.
        for (int ph = 0; ph < 14; ph++)
        begin
            random_settings();
            if (ph == 13)
                quiet = 1'b1;
            push_random(100);
            drain_block();
        end

        $display("Checked %0d output pairs from %0d frames across settings", pairs_checked,
                 frames_sent);
        $display("including full rate, zero ratio, step and alpha extremes, dither and shaping.");
        if (fail_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
